// File: sv/pprq_pkg.sv
package pprq_pkg;

    // Request kinds carried on s_tuser
    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_PICK    = 2'd1;
    localparam logic [1:0] ACT_STEAL   = 2'd2;

    localparam int ACT_BITS = 2;

endpackage

// File: sv/pprq_ram.sv
module pprq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/preemptive_priority_run_queue.sv
// Preemptive priority run queue.
// Requests enter on the s_ channel: s_tuser selects enqueue, pick (remove
// head) or steal (remove tail); s_tdata carries the task and its context.
// Every request yields exactly one result on the m_ channel, carrying the
// removed task id, the reschedule and drop flags and the queue count.
// Tasks live in one RAM, kept as a circular buffer sorted by ascending
// priority. Pick and steal read the RAM, then capture the result, then
// load the output register. An enqueue walks the queue from the tail,
// moving one entry up per cycle through the RAM's read and write ports.
// Skipped, dropped and empty-queue requests go straight to the output
// register. One request is in work at a time; a new one is taken once
// the previous result sits in the output register.
// Reset empties the queue at once; the RAM contents need no clearing.
// When the receiver stalls, the result is held in the output register
// and the next request is processed up to its result, then waits.
module preemptive_priority_run_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PRIO_BITS   = 8,
    parameter int ID_BITS     = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // s_tdata fields, low bit up: task_id, task_prio, already_queued,
    // is_idle, insert_front, preempted, running_prio, zero pad
    input  logic [((ID_BITS+2*PRIO_BITS+4+7)/8)*8-1:0] s_tdata,
    // s_tuser fields, low bit up: action
    input  logic [pprq_pkg::ACT_BITS-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // m_tdata fields, low bit up: out_task_id, out_valid, resched_req,
    // mark_running_front, dropped_full, queue_count, zero pad
    output logic [((ID_BITS+4+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    import pprq_pkg::*;

    localparam int AW       = $clog2(QUEUE_DEPTH);
    localparam int CW       = $clog2(QUEUE_DEPTH+1);
    localparam int EW       = ID_BITS + PRIO_BITS;
    localparam int M_W      = ((ID_BITS+4+CW+7)/8)*8;
    localparam int OFS_PRIO = ID_BITS;
    localparam int OFS_QUE  = ID_BITS + PRIO_BITS;
    localparam int OFS_IDLE = OFS_QUE + 1;
    localparam int OFS_FRNT = OFS_QUE + 2;
    localparam int OFS_PRE  = OFS_QUE + 3;
    localparam int OFS_RUN  = OFS_QUE + 4;

    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH-1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_REMOVE,
        ST_FINISH
    } state_t;

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - 1'b1;
    endfunction

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        left_reg, left_next;
    logic [ID_BITS-1:0]   new_id_reg, new_id_next;
    logic [PRIO_BITS-1:0] new_prio_reg, new_prio_next;
    logic                 front_reg, front_next;
    logic [ID_BITS-1:0]   res_id_reg, res_id_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 res_resched_reg, res_resched_next;
    logic                 res_dropped_reg, res_dropped_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_W-1:0]       m_tdata_reg, m_tdata_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;

    logic [ID_BITS-1:0]   in_id;
    logic [PRIO_BITS-1:0] in_prio;
    logic [PRIO_BITS-1:0] in_run_prio;
    logic                 in_resched;
    logic [PRIO_BITS-1:0] rd_prio;
    logic                 move_up;

    // Split the request fields
    assign in_id       = s_tdata[ID_BITS-1:0];
    assign in_prio     = s_tdata[OFS_PRIO +: PRIO_BITS];
    assign in_run_prio = s_tdata[OFS_RUN +: PRIO_BITS];
    assign in_resched  = !s_tdata[OFS_PRE] && (in_prio < in_run_prio);

    // Decide whether the entry just read shifts toward the tail
    assign rd_prio = ram_rdata[PRIO_BITS-1:0];
    assign move_up = front_reg ? (rd_prio >= new_prio_reg) : (rd_prio > new_prio_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    pprq_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Sequence each request through the RAM
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        ptr_next         = ptr_reg;
        left_next        = left_reg;
        new_id_next      = new_id_reg;
        new_prio_next    = new_prio_reg;
        front_next       = front_reg;
        res_id_next      = res_id_reg;
        res_valid_next   = res_valid_reg;
        res_resched_next = res_resched_reg;
        res_dropped_next = res_dropped_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        ram_we           = 1'b0;
        ram_waddr        = ptr_reg;
        ram_wdata        = {new_id_reg, new_prio_reg};
        ram_re           = 1'b0;
        ram_raddr        = head_reg;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    new_id_next      = in_id;
                    new_prio_next    = in_prio;
                    front_next       = s_tdata[OFS_FRNT];
                    res_id_next      = '0;
                    res_valid_next   = 1'b0;
                    res_resched_next = 1'b0;
                    res_dropped_next = 1'b0;
                    state_next       = ST_FINISH;
                    unique case (s_tuser)
                        ACT_ENQUEUE:
                        begin
                            if (s_tdata[OFS_QUE] || s_tdata[OFS_IDLE])
                            begin
                                state_next = ST_FINISH;
                            end
                            else if (count_reg == FULL_CNT)
                            begin
                                res_dropped_next = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we           = 1'b1;
                                ram_waddr        = tail_reg;
                                ram_wdata        = {in_id, in_prio};
                                tail_next        = addr_inc(tail_reg);
                                count_next       = count_reg + 1'b1;
                                res_resched_next = in_resched;
                            end
                            else
                            begin
                                ram_re           = 1'b1;
                                ram_raddr        = addr_dec(tail_reg);
                                ptr_next         = addr_dec(tail_reg);
                                left_next        = AW'(count_reg - 1'b1);
                                res_resched_next = in_resched;
                                state_next       = ST_SCAN;
                            end
                        end
                        ACT_PICK:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                head_next  = addr_inc(head_reg);
                                count_next = count_reg - 1'b1;
                                state_next = ST_REMOVE;
                            end
                        end
                        ACT_STEAL:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = addr_dec(tail_reg);
                                tail_next  = addr_dec(tail_reg);
                                count_next = count_reg - 1'b1;
                                state_next = ST_REMOVE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Write either the shifted entry or the new task one slot up
                ram_we    = 1'b1;
                ram_waddr = addr_inc(ptr_reg);
                if (move_up)
                begin
                    ram_wdata = ram_rdata;
                    if (left_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = addr_dec(ptr_reg);
                        ptr_next   = addr_dec(ptr_reg);
                        left_next  = left_reg - 1'b1;
                    end
                end
                else
                begin
                    tail_next  = addr_inc(tail_reg);
                    count_next = count_reg + 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_PLACE:
            begin
                // New task becomes the head
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                tail_next  = addr_inc(tail_reg);
                count_next = count_reg + 1'b1;
                state_next = ST_FINISH;
            end
            ST_REMOVE:
            begin
                res_id_next    = ram_rdata[EW-1:PRIO_BITS];
                res_valid_next = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_W'({count_reg, res_dropped_reg, res_resched_reg,
                                          res_resched_reg, res_valid_reg, res_id_reg});
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, pointers and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            ptr_reg         <= '0;
            left_reg        <= '0;
            new_id_reg      <= '0;
            new_prio_reg    <= '0;
            front_reg       <= 1'b0;
            res_id_reg      <= '0;
            res_valid_reg   <= 1'b0;
            res_resched_reg <= 1'b0;
            res_dropped_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            ptr_reg         <= ptr_next;
            left_reg        <= left_next;
            new_id_reg      <= new_id_next;
            new_prio_reg    <= new_prio_next;
            front_reg       <= front_next;
            res_id_reg      <= res_id_next;
            res_valid_reg   <= res_valid_next;
            res_resched_reg <= res_resched_next;
            res_dropped_reg <= res_dropped_next;
            m_tvalid_reg    <= m_tvalid_next;
            m_tdata_reg     <= m_tdata_next;
        end
    end

endmodule
